### hw/rtl/char_lcd_bus_write_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD bus write sequencer
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_BUS_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_BUS_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define CLWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg
// Types, codes and step decode shared by the LCD write sequencer modules.
// ----------------------------------------------------------------------------
package clws_pkg;

  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_CHAR    = 2'd1,
    OP_CURSOR  = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STEP_SELECT  = 3'd0,
    STEP_EN_HI   = 3'd1,
    STEP_DATA_HI = 3'd2,
    STEP_EN_LO   = 3'd3,
    STEP_EN_HI2  = 3'd4,
    STEP_DATA_LO = 3'd5,
    STEP_EN_LO2  = 3'd6
  } step_idx_t;

  localparam logic [7:0] SET_ADDR_BIT = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       rs;
    logic [7:0] byte_val;
    logic       four_bit;
  } job_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic       data_drive;
    logic [7:0] data_lines;
    logic       wait_after;
    logic       last_step;
  } step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h10;
      default: off = 8'h50;
    endcase
    return off;
  endfunction

  function automatic step_t step_decode(input job_t job, input step_idx_t idx);
    step_t s;
    s = '0;
    s.reg_select = job.rs;
    if (job.four_bit) begin
      case (idx)
        STEP_SELECT:  s.wait_after = 1'b1;
        STEP_EN_HI:   begin s.enable = 1'b1; s.wait_after = 1'b1; end
        STEP_DATA_HI: begin
          s.enable     = 1'b1;
          s.data_drive = 1'b1;
          s.data_lines = {4'd0, job.byte_val[7:4]};
          s.wait_after = 1'b1;
        end
        STEP_EN_LO:   s.wait_after = 1'b1;
        STEP_EN_HI2:  begin s.enable = 1'b1; s.wait_after = 1'b1; end
        STEP_DATA_LO: begin
          s.enable     = 1'b1;
          s.data_drive = 1'b1;
          s.data_lines = {4'd0, job.byte_val[3:0]};
          s.wait_after = 1'b1;
        end
        STEP_EN_LO2:  s.last_step = 1'b1;
        default:      s.last_step = 1'b1;
      endcase
    end else begin
      case (idx)
        STEP_SELECT:  s.wait_after = 1'b1;
        STEP_EN_HI:   begin s.enable = 1'b1; s.wait_after = 1'b1; end
        STEP_DATA_HI: begin
          s.enable     = 1'b1;
          s.data_drive = 1'b1;
          s.data_lines = job.byte_val;
        end
        default:      s.last_step = 1'b1;
      endcase
    end
    return s;
  endfunction

endpackage

### hw/rtl/char_lcd_bus_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_bus_write_sequencer
// Expands command, character and cursor-move requests into LCD pin steps.
//
// Input channel (in_valid/in_ready): one request word per handshake.
// Opcode 3 is taken and dropped without output. Output channel
// (out_valid/out_ready): one pin step per word, seven steps per request
// in 4-bit mode and four in 8-bit mode; last_step flags the end of a run.
// Throughput: one step per cycle while the receiver takes them; queued
// requests follow with no gap, as the step counter of the back sequencer
// reloads from the queue on the last step. From idle, an accepted request
// goes through queue, job and output registers. A two-entry job queue lets
// new requests be taken while a run is still being stepped out.
// A stalled receiver holds the current step on the output register; the
// sequencer and then the queue fill, and in_ready drops when it is full.
// Reset empties the queue, clears out_valid and sets four_bit_mode to 1.
// cfg_wr_en/cfg_wr_data write four_bit_mode; the mode is latched per job.
// ----------------------------------------------------------------------------
module char_lcd_bus_write_sequencer
  import clws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_byte_value,
  input  logic [1:0] in_row,
  input  logic [5:0] in_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_reg_select,
  output logic       out_enable,
  output logic       out_data_drive,
  output logic [7:0] out_data_lines,
  output logic       out_wait_after,
  output logic       out_last_step
);

  queue_stat_t q_stat;
  logic        q_push, q_pop;
  job_t        q_job, q_head;
  step_t       step;

  clws_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  clws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .stat     (q_stat)
  );

  clws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_step  (step)
  );

  assign out_reg_select = step.reg_select;
  assign out_enable     = step.enable;
  assign out_data_drive = step.data_drive;
  assign out_data_lines = step.data_lines;
  assign out_wait_after = step.wait_after;
  assign out_last_step  = step.last_step;

endmodule

### hw/rtl/clws_front.sv
// ----------------------------------------------------------------------------
// clws_front
// Accepts request words, resolves the byte to send and queues the job.
// ----------------------------------------------------------------------------
module clws_front
  import clws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_byte_value,
  input  logic [1:0]  in_row,
  input  logic [5:0]  in_column,
  input  queue_stat_t q_stat,
  output logic        q_push,
  output job_t        q_job
);

  logic       four_bit_r;
  logic [7:0] addr_sum;
  opcode_t    op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b1;
    end else if (cfg_wr_en) begin
      four_bit_r <= cfg_wr_data;
    end
  end

  assign op       = opcode_t'(in_opcode);
  assign addr_sum = {2'd0, in_column} + row_offset(in_row);
  assign in_ready = !q_stat.full;

  always_comb begin
    q_job.four_bit = four_bit_r;
    q_job.rs       = 1'b0;
    q_job.byte_val = in_byte_value;
    q_push         = in_valid && in_ready;
    case (op)
      OP_COMMAND: q_job.rs = 1'b0;
      OP_CHAR:    q_job.rs = 1'b1;
      OP_CURSOR:  q_job.byte_val = addr_sum | SET_ADDR_BIT;
      default:    q_push = 1'b0;
    endcase
  end

endmodule

### hw/rtl/clws_queue.sv
// ----------------------------------------------------------------------------
// clws_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module clws_queue
  import clws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        head_job,
  output queue_stat_t stat
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == CntW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CntW'(1);
        2'b01:   count_r <= count_r - CntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hw/rtl/clws_back.sv
// ----------------------------------------------------------------------------
// clws_back
// Steps through the pin sequence of one job per run, one step a cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module clws_back
  import clws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t q_stat,
  input  job_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output step_t       out_step
);

  job_t      job_r, job_nxt;
  logic      job_vld_r, job_vld_nxt;
  step_idx_t step_r, step_nxt;
  logic      out_vld_r, out_vld_nxt;
  step_t     out_step_r, out_step_nxt;
  step_t     cur;
  logic      load;

  assign cur       = step_decode(job_r, step_r);
  assign load      = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_step  = out_step_r;

  always_comb begin
    job_nxt      = job_r;
    job_vld_nxt  = job_vld_r;
    step_nxt     = step_r;
    out_vld_nxt  = out_vld_r;
    out_step_nxt = out_step_r;
    q_pop        = 1'b0;
    if (load) begin
      out_vld_nxt = job_vld_r;
      if (job_vld_r) begin
        out_step_nxt = cur;
      end
      if (!job_vld_r || cur.last_step) begin
        q_pop       = !q_stat.empty;
        job_vld_nxt = !q_stat.empty;
        job_nxt     = q_head;
        step_nxt    = STEP_SELECT;
      end else begin
        step_nxt = step_idx_t'(step_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      step_r    <= STEP_SELECT;
    end else begin
      job_vld_r <= job_vld_nxt;
      out_vld_r <= out_vld_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_step_r <= out_step_nxt;
  end

endmodule

### hw/rtl/clws_checker.sv
// ----------------------------------------------------------------------------
// clws_checker
// Port-level checks on the LCD write sequencer output words.
// ----------------------------------------------------------------------------
`include "char_lcd_bus_write_sequencer_assert.svh"

module clws_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_enable,
  input logic       out_data_drive,
  input logic [7:0] out_data_lines,
  input logic       out_wait_after,
  input logic       out_last_step
);

  `CLWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data_lines) && $stable(out_last_step),
    "stalled output word changed")
  `CLWS_ASSERT_NOW(a_idle_lines, out_valid && !out_data_drive, out_data_lines == 8'd0,
    "data lines nonzero without drive")
  `CLWS_ASSERT_NOW(a_drive_en, out_valid && out_data_drive, out_enable,
    "data driven while enable low")
  `CLWS_ASSERT_NOW(a_last_quiet, out_valid && out_last_step,
    !out_enable && !out_data_drive && !out_wait_after, "last step not an idle enable-low")

endmodule

bind char_lcd_bus_write_sequencer clws_checker u_clws_checker (.*);
